// ----- src/tlv_stream_deframer_top_assert.svh -----
// Assertion macros used by the deframer parser.
`ifndef TLV_STREAM_DEFRAMER_TOP_ASSERT_SVH
`define TLV_STREAM_DEFRAMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TSD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSD_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TSD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/tsd_pkg.sv -----
// Types, codes and decode functions of the TLV stream deframer.
`default_nettype none

package tsd_pkg;

    // Configuration port geometry
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Parser phase
    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_LEN_HI  = 2'd1,
        PH_LEN_LO  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // Item kind codes
    localparam logic [3:0] KIND_LIST_START = 4'd0;
    localparam logic [3:0] KIND_LIST_STOP  = 4'd1;
    localparam logic [3:0] KIND_STRING     = 4'd2;
    localparam logic [3:0] KIND_RAW        = 4'd3;
    localparam logic [3:0] KIND_U64        = 4'd4;
    localparam logic [3:0] KIND_U32        = 4'd5;
    localparam logic [3:0] KIND_U16        = 4'd6;
    localparam logic [3:0] KIND_U8         = 4'd7;
    localparam logic [3:0] KIND_ADDR       = 4'd8;

    // Tag byte values
    localparam logic [7:0] TAG_LIST_START = 8'h01;
    localparam logic [7:0] TAG_LIST_STOP  = 8'h02;
    localparam logic [7:0] TAG_STRING     = 8'h04;
    localparam logic [7:0] TAG_RAW        = 8'h05;
    localparam logic [7:0] TAG_U64        = 8'h06;
    localparam logic [7:0] TAG_U32        = 8'h07;
    localparam logic [7:0] TAG_U16        = 8'h08;
    localparam logic [7:0] TAG_U8         = 8'h09;
    localparam logic [7:0] TAG_ADDR       = 8'h0a;

    // Byte roles
    localparam logic [1:0] ROLE_TAG     = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_TAG  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    // Register indexes
    localparam logic REG_MAX_RAW_LENGTH = 1'b0;

    localparam logic [15:0] MAX_RAW_LENGTH_RST = 16'hffff;

    typedef struct packed {
        logic [7:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  byte_role;
        logic [3:0]  item_kind;
        logic [15:0] payload_index;
        logic [15:0] item_length;
        logic        item_end;
        logic [63:0] int_value;
        logic [1:0]  error_code;
    } out_item_t;

    typedef struct packed {
        logic       known;
        logic [3:0] kind;
    } tag_dec_t;

    // Map a tag byte to its kind
    function automatic tag_dec_t decode_tag(input logic [7:0] tag);
        tag_dec_t d;
        d.known = 1'b1;
        case (tag)
            TAG_LIST_START: d.kind = KIND_LIST_START;
            TAG_LIST_STOP:  d.kind = KIND_LIST_STOP;
            TAG_STRING:     d.kind = KIND_STRING;
            TAG_RAW:        d.kind = KIND_RAW;
            TAG_U64:        d.kind = KIND_U64;
            TAG_U32:        d.kind = KIND_U32;
            TAG_U16:        d.kind = KIND_U16;
            TAG_U8:         d.kind = KIND_U8;
            TAG_ADDR:       d.kind = KIND_ADDR;
            default:
            begin
                d.known = 1'b0;
                d.kind  = KIND_LIST_START;
            end
        endcase
        return d;
    endfunction

    // Payload length of the fixed-size kinds
    function automatic logic [15:0] fixed_length(input logic [3:0] kind);
        logic [15:0] len;
        case (kind)
            KIND_U64:  len = 16'd8;
            KIND_U32:  len = 16'd4;
            KIND_U16:  len = 16'd2;
            KIND_U8:   len = 16'd1;
            KIND_ADDR: len = 16'd16;
            default:   len = 16'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- src/tsd_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per transaction.
`default_nettype none

interface tsd_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/tsd_cfg.sv -----
// APB-style configuration register block for the deframer.
`default_nettype none

module tsd_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tsd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tsd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tsd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output logic      [15:0]                  max_raw_length
);

    logic [15:0] max_len_reg;
    logic [15:0] max_len_next;
    logic        wr_hit;

    // Decode a write to the length limit register
    assign wr_hit = psel && penable && pwrite
                    && (paddr[tsd_pkg::PADDR_W-1] == tsd_pkg::REG_MAX_RAW_LENGTH);

    assign max_len_next = wr_hit ? pwdata[15:0] : max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= tsd_pkg::MAX_RAW_LENGTH_RST;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    // Return the register on reads, zero elsewhere
    always_comb
    begin
        if (paddr[tsd_pkg::PADDR_W-1] == tsd_pkg::REG_MAX_RAW_LENGTH)
        begin
            prdata = {{(tsd_pkg::PDATA_W-16){1'b0}}, max_len_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready         = 1'b1;
    assign max_raw_length = max_len_reg;

endmodule

`default_nettype wire

// ----- src/tsd_parser.sv -----
// Per-byte parse state and result decode of the TLV stream.
`default_nettype none

`include "tlv_stream_deframer_top_assert.svh"

module tsd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          in_byte,
    input  wire logic [15:0]         max_raw_length,
    output tsd_pkg::out_item_t       result
);

    tsd_pkg::phase_t phase_reg;
    tsd_pkg::phase_t phase_next;
    logic [3:0]      kind_reg;
    logic [3:0]      kind_next;
    logic [7:0]      len_hi_reg;
    logic [7:0]      len_hi_next;
    logic [15:0]     remain_reg;
    logic [15:0]     remain_next;
    logic [15:0]     offset_reg;
    logic [15:0]     offset_next;
    logic [15:0]     length_reg;
    logic [15:0]     length_next;
    logic [63:0]     acc_reg;
    logic [63:0]     acc_next;
    logic            too_long_reg;
    logic            too_long_next;

    tsd_pkg::tag_dec_t tag_dec;
    logic [15:0]     fix_len;
    logic [15:0]     lo_len;
    logic            lo_too_long;
    logic [15:0]     remain_dec;
    logic [63:0]     acc_shift;
    logic            is_int_kind;
    logic            list_kind;
    logic            var_kind;

    // Shared decode terms
    assign tag_dec     = tsd_pkg::decode_tag(in_byte);
    assign fix_len     = tsd_pkg::fixed_length(tag_dec.kind);
    assign lo_len      = {len_hi_reg, in_byte};
    assign lo_too_long = (kind_reg == tsd_pkg::KIND_RAW) && (lo_len > max_raw_length);
    assign remain_dec  = (remain_reg == 16'd0) ? 16'd0 : remain_reg - 16'd1;
    assign acc_shift   = {acc_reg[55:0], in_byte};
    assign is_int_kind = (kind_reg >= tsd_pkg::KIND_U64) && (kind_reg <= tsd_pkg::KIND_U8);
    assign list_kind   = (tag_dec.kind == tsd_pkg::KIND_LIST_START)
                         || (tag_dec.kind == tsd_pkg::KIND_LIST_STOP);
    assign var_kind    = (tag_dec.kind == tsd_pkg::KIND_STRING)
                         || (tag_dec.kind == tsd_pkg::KIND_RAW);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            tsd_pkg::PH_TAG:
            begin
                if (tag_dec.known && var_kind)
                begin
                    phase_next = tsd_pkg::PH_LEN_HI;
                end
                else if (tag_dec.known && !list_kind)
                begin
                    phase_next = tsd_pkg::PH_PAYLOAD;
                end
            end
            tsd_pkg::PH_LEN_HI:
            begin
                phase_next = tsd_pkg::PH_LEN_LO;
            end
            tsd_pkg::PH_LEN_LO:
            begin
                phase_next = (lo_len == 16'd0) ? tsd_pkg::PH_TAG : tsd_pkg::PH_PAYLOAD;
            end
            tsd_pkg::PH_PAYLOAD:
            begin
                if (remain_dec == 16'd0)
                begin
                    phase_next = tsd_pkg::PH_TAG;
                end
            end
            default:
            begin
                phase_next = tsd_pkg::PH_TAG;
            end
        endcase
    end

    // Datapath updates and result fields
    always_comb
    begin
        kind_next     = kind_reg;
        len_hi_next   = len_hi_reg;
        remain_next   = remain_reg;
        offset_next   = offset_reg;
        length_next   = length_reg;
        acc_next      = acc_reg;
        too_long_next = too_long_reg;

        result               = '0;
        result.data_byte     = in_byte;

        case (phase_reg)
            tsd_pkg::PH_TAG:
            begin
                result.byte_role = tsd_pkg::ROLE_TAG;
                if (!tag_dec.known)
                begin
                    result.error_code = tsd_pkg::ERR_BAD_TAG;
                    result.item_end   = 1'b1;
                end
                else
                begin
                    kind_next        = tag_dec.kind;
                    result.item_kind = tag_dec.kind;
                    too_long_next    = 1'b0;
                    acc_next         = '0;
                    offset_next      = '0;
                    if (list_kind)
                    begin
                        length_next     = '0;
                        result.item_end = 1'b1;
                    end
                    else if (var_kind)
                    begin
                        length_next = '0;
                    end
                    else
                    begin
                        length_next        = fix_len;
                        remain_next        = fix_len;
                        result.item_length = fix_len;
                    end
                end
            end
            tsd_pkg::PH_LEN_HI:
            begin
                result.byte_role = tsd_pkg::ROLE_LENGTH;
                result.item_kind = kind_reg;
                len_hi_next      = in_byte;
            end
            tsd_pkg::PH_LEN_LO:
            begin
                result.byte_role   = tsd_pkg::ROLE_LENGTH;
                result.item_kind   = kind_reg;
                length_next        = lo_len;
                result.item_length = lo_len;
                too_long_next      = lo_too_long;
                if (lo_too_long)
                begin
                    result.error_code = tsd_pkg::ERR_TOO_LONG;
                end
                if (lo_len == 16'd0)
                begin
                    result.item_end = 1'b1;
                    too_long_next   = 1'b0;
                end
                else
                begin
                    remain_next = lo_len;
                    offset_next = '0;
                end
            end
            tsd_pkg::PH_PAYLOAD:
            begin
                result.byte_role     = tsd_pkg::ROLE_PAYLOAD;
                result.item_kind     = kind_reg;
                result.payload_index = offset_reg;
                result.item_length   = length_reg;
                if (too_long_reg)
                begin
                    result.error_code = tsd_pkg::ERR_TOO_LONG;
                end
                acc_next    = acc_shift;
                offset_next = offset_reg + 16'd1;
                remain_next = remain_dec;
                if (remain_dec == 16'd0)
                begin
                    result.item_end = 1'b1;
                    too_long_next   = 1'b0;
                    if (is_int_kind)
                    begin
                        result.int_value = acc_shift;
                    end
                end
            end
            default:
            begin
                result.byte_role = tsd_pkg::ROLE_TAG;
            end
        endcase
    end

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tsd_pkg::PH_TAG;
            kind_reg     <= '0;
            len_hi_reg   <= '0;
            remain_reg   <= '0;
            offset_reg   <= '0;
            length_reg   <= '0;
            acc_reg      <= '0;
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            len_hi_reg   <= len_hi_next;
            remain_reg   <= remain_next;
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            acc_reg      <= acc_next;
            too_long_reg <= too_long_next;
        end
    end

    // A high length byte is always followed by the low one
    `TSD_ASSERT_RST(a_len_order, clk, rst_n,
        accept && (phase_reg == tsd_pkg::PH_LEN_HI) |=> (phase_reg == tsd_pkg::PH_LEN_LO),
        "low length byte did not follow high length byte")

    // Payload offset and remaining count always add up to the item length
    `TSD_ASSERT_RST(a_offset_sum, clk, rst_n,
        (phase_reg == tsd_pkg::PH_PAYLOAD) |-> (offset_reg + remain_reg == length_reg),
        "payload offset and remaining count disagree with item length")

    // Too-long errors belong to raw items only
    `TSD_ASSERT_RST(a_too_long_raw, clk, rst_n,
        too_long_reg |-> (kind_reg == tsd_pkg::KIND_RAW),
        "too-long flag set on a non-raw item")

    // Item end on a payload byte returns the parser to the tag phase
    `TSD_ASSERT_RST(a_end_to_tag, clk, rst_n,
        accept && result.item_end && (phase_reg == tsd_pkg::PH_PAYLOAD)
            |=> (phase_reg == tsd_pkg::PH_TAG),
        "parser did not return to tag after item end")

endmodule

`default_nettype wire

// ----- src/tsd_out_reg.sv -----
// Result register between the parser and the output channel.
`default_nettype none

module tsd_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire tsd_pkg::out_item_t  result,
    output logic                     can_load,
    tsd_stream_if.source             sink_ch
);

    logic               valid_reg;
    logic               valid_next;
    tsd_pkg::out_item_t data_reg;

    // Take a new result when empty or when the held one leaves this cycle
    assign can_load   = !valid_reg || sink_ch.ready;
    assign valid_next = load || (valid_reg && !sink_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign sink_ch.valid = valid_reg;
    assign sink_ch.data  = data_reg;

endmodule

`default_nettype wire

// ----- src/tlv_stream_deframer_top.sv -----
// Top level of the TLV stream deframer.
//
// Usage:
//   stream carries one byte of a tagged stream per transaction; result carries
//   one decoded record per byte: role, kind, payload index, item length, item
//   end, assembled integer value and error code.
//   The APB-style port holds max_raw_length at byte address 0 (reset 65535);
//   write it only while no byte is in flight.
// Timing:
//   A byte accepted at a clock edge appears on result in the next cycle. One
//   byte is accepted every cycle unless result stalls; the rate is set by the
//   single result register fed from the parse state update.
// Reset:
//   rst_n clears the parse state to "expecting tag", empties the result
//   register and restores the length limit.
// Stall:
//   While result is stalled with a record held, stream.ready drops; it rises
//   again in the cycle the held record is taken, so no cycle is lost.
`default_nettype none

module tlv_stream_deframer_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tsd_stream_if.sink                        stream,
    tsd_stream_if.source                      result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tsd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tsd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tsd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    logic               can_load;
    logic               accept;
    logic [15:0]        max_raw_length;
    tsd_pkg::out_item_t parsed;

    // Accept a byte whenever the result register can take its record
    assign stream.ready = can_load;
    assign accept       = stream.valid && can_load;

    tsd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .max_raw_length (max_raw_length)
    );

    tsd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_byte        (stream.data.in_byte),
        .max_raw_length (max_raw_length),
        .result         (parsed)
    );

    tsd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (parsed),
        .can_load (can_load),
        .sink_ch  (result)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the TLV stream deframer: directed, limit and random byte streams.
`default_nettype none

module tb_top;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_BYTES  = 1000;
    localparam int unsigned PHASE_BYTES   = 150;

    // Register map: one 16-bit register at index 0, next word is unmapped
    localparam logic [tsd_pkg::PADDR_W-1:0] ADDR_MAX_RAW_LENGTH =
        {tsd_pkg::REG_MAX_RAW_LENGTH, 2'b00};
    localparam logic [tsd_pkg::PADDR_W-1:0] ADDR_UNMAPPED       = {1'b1, 2'b00};

    localparam logic [7:0] KNOWN_TAGS [9] = '{tsd_pkg::TAG_LIST_START, tsd_pkg::TAG_LIST_STOP,
                                              tsd_pkg::TAG_STRING, tsd_pkg::TAG_RAW,
                                              tsd_pkg::TAG_U64, tsd_pkg::TAG_U32,
                                              tsd_pkg::TAG_U16, tsd_pkg::TAG_U8,
                                              tsd_pkg::TAG_ADDR};

    typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
    typedef enum int unsigned {RX_ALWAYS, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tsd_pkg::PADDR_W-1:0] paddr;
    logic [tsd_pkg::PDATA_W-1:0] pwdata;
    logic [tsd_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    tsd_stream_if #(.item_t(tsd_pkg::in_item_t))  stream_ch ();
    tsd_stream_if #(.item_t(tsd_pkg::out_item_t)) result_ch ();

    tlv_stream_deframer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Parser state mirrored by the predictor
    tsd_pkg::phase_t ps_phase     = tsd_pkg::PH_TAG;
    logic [3:0]      ps_kind      = '0;
    logic [7:0]      ps_len_hi    = '0;
    logic [15:0]     ps_remaining = '0;
    logic [15:0]     ps_offset    = '0;
    logic [15:0]     ps_length    = '0;
    logic [63:0]     ps_value     = '0;
    logic            ps_too_long  = 1'b0;
    logic [15:0]     raw_limit    = tsd_pkg::MAX_RAW_LENGTH_RST;

    tsd_pkg::out_item_t pending_records [$];
    int unsigned fail_count  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned burst_left  = 0;
    bit          sending     = 1'b0;
    bit          gaps_on     = 1'b1;

    int unsigned rx_cycle    = 0;
    int unsigned rx_hold     = 0;
    logic        rx_level    = 1'b1;
    rx_mode_t    rx_mode     = RX_ALWAYS;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the parser by one byte and return the record it must produce
    function automatic tsd_pkg::out_item_t deframe_byte(input logic [7:0] b);
        tsd_pkg::out_item_t rec;
        logic               known;
        logic [3:0]         k;
        rec = '0;
        rec.data_byte = b;
        case (ps_phase)
            tsd_pkg::PH_TAG:
            begin
                rec.byte_role = tsd_pkg::ROLE_TAG;
                known = 1'b1;
                k = tsd_pkg::KIND_LIST_START;
                case (b)
                    tsd_pkg::TAG_LIST_START: k = tsd_pkg::KIND_LIST_START;
                    tsd_pkg::TAG_LIST_STOP:  k = tsd_pkg::KIND_LIST_STOP;
                    tsd_pkg::TAG_STRING:     k = tsd_pkg::KIND_STRING;
                    tsd_pkg::TAG_RAW:        k = tsd_pkg::KIND_RAW;
                    tsd_pkg::TAG_U64:        k = tsd_pkg::KIND_U64;
                    tsd_pkg::TAG_U32:        k = tsd_pkg::KIND_U32;
                    tsd_pkg::TAG_U16:        k = tsd_pkg::KIND_U16;
                    tsd_pkg::TAG_U8:         k = tsd_pkg::KIND_U8;
                    tsd_pkg::TAG_ADDR:       k = tsd_pkg::KIND_ADDR;
                    default:                 known = 1'b0;
                endcase
                if (!known)
                begin
                    // Unknown tag: flag it and stay on the tag phase
                    rec.error_code = tsd_pkg::ERR_BAD_TAG;
                    rec.item_end   = 1'b1;
                end
                else
                begin
                    ps_kind       = k;
                    rec.item_kind = k;
                    ps_too_long   = 1'b0;
                    ps_value      = '0;
                    ps_offset     = '0;
                    if (k == tsd_pkg::KIND_LIST_START || k == tsd_pkg::KIND_LIST_STOP)
                    begin
                        ps_length    = '0;
                        rec.item_end = 1'b1;
                    end
                    else if (k == tsd_pkg::KIND_STRING || k == tsd_pkg::KIND_RAW)
                    begin
                        ps_length = '0;
                        ps_phase  = tsd_pkg::PH_LEN_HI;
                    end
                    else
                    begin
                        case (k)
                            tsd_pkg::KIND_U64: ps_length = 16'd8;
                            tsd_pkg::KIND_U32: ps_length = 16'd4;
                            tsd_pkg::KIND_U16: ps_length = 16'd2;
                            tsd_pkg::KIND_U8:  ps_length = 16'd1;
                            default:           ps_length = 16'd16;
                        endcase
                        ps_remaining    = ps_length;
                        rec.item_length = ps_length;
                        ps_phase        = tsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            tsd_pkg::PH_LEN_HI:
            begin
                rec.byte_role = tsd_pkg::ROLE_LENGTH;
                rec.item_kind = ps_kind;
                ps_len_hi     = b;
                ps_phase      = tsd_pkg::PH_LEN_LO;
            end
            tsd_pkg::PH_LEN_LO:
            begin
                rec.byte_role   = tsd_pkg::ROLE_LENGTH;
                rec.item_kind   = ps_kind;
                ps_length       = {ps_len_hi, b};
                rec.item_length = ps_length;
                ps_too_long     = (ps_kind == tsd_pkg::KIND_RAW) && (ps_length > raw_limit);
                if (ps_too_long)
                    rec.error_code = tsd_pkg::ERR_TOO_LONG;
                if (ps_length == 16'd0)
                begin
                    // Empty string or raw ends on its low length byte
                    rec.item_end = 1'b1;
                    ps_too_long  = 1'b0;
                    ps_phase     = tsd_pkg::PH_TAG;
                end
                else
                begin
                    ps_remaining = ps_length;
                    ps_offset    = '0;
                    ps_phase     = tsd_pkg::PH_PAYLOAD;
                end
            end
            default:
            begin
                rec.byte_role     = tsd_pkg::ROLE_PAYLOAD;
                rec.item_kind     = ps_kind;
                rec.payload_index = ps_offset;
                rec.item_length   = ps_length;
                if (ps_too_long)
                    rec.error_code = tsd_pkg::ERR_TOO_LONG;
                ps_value  = {ps_value[55:0], b};
                ps_offset = ps_offset + 16'd1;
                if (ps_remaining != 16'd0)
                    ps_remaining = ps_remaining - 16'd1;
                if (ps_remaining == 16'd0)
                begin
                    rec.item_end = 1'b1;
                    if (ps_kind >= tsd_pkg::KIND_U64 && ps_kind <= tsd_pkg::KIND_U8)
                        rec.int_value = ps_value;
                    ps_too_long = 1'b0;
                    ps_phase    = tsd_pkg::PH_TAG;
                end
            end
        endcase
        return rec;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Check each result transaction and drive the receiver stall pattern
    always @(posedge clk)
    begin : rx_side
        tsd_pkg::out_item_t want;
        tsd_pkg::out_item_t got;
        if (result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_records.size() == 0)
            begin
                $error("unexpected result transaction, data_byte %0h", got.data_byte);
                fail_count++;
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("data_byte",     64'(want.data_byte),     64'(got.data_byte));
                check_field("byte_role",     64'(want.byte_role),     64'(got.byte_role));
                check_field("item_kind",     64'(want.item_kind),     64'(got.item_kind));
                check_field("payload_index", 64'(want.payload_index), 64'(got.payload_index));
                check_field("item_length",   64'(want.item_length),   64'(got.item_length));
                check_field("item_end",      64'(want.item_end),      64'(got.item_end));
                check_field("int_value",     want.int_value,          got.int_value);
                check_field("error_code",    64'(want.error_code),    64'(got.error_code));
            end
        end

        rx_cycle++;
        if (rx_cycle % 256 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_ALWAYS: result_ch.ready <= 1'b1;
            RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                // Alternate runs of ready and stall of random length
                if (rx_hold == 0)
                begin
                    rx_level = ~rx_level;
                    rx_hold  = $urandom_range(1, 10);
                end
                rx_hold--;
                result_ch.ready <= rx_level;
            end
        endcase
    end

    // Send one byte, record its expected result, then maybe end the burst
    task automatic send_byte(input logic [7:0] b);
        stream_ch.valid <= 1'b1;
        stream_ch.data  <= b;
        sending = 1'b1;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        pending_records.push_back(deframe_byte(b));
        bytes_sent++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                stream_ch.valid <= 1'b0;
                sending = 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    // Send a tag, its length bytes where the kind has them, and the payload
    task automatic send_tlv(input logic [7:0] tag, input int unsigned len, input fill_t fill);
        int unsigned n;
        logic [7:0]  b;
        send_byte(tag);
        case (tag)
            tsd_pkg::TAG_STRING, tsd_pkg::TAG_RAW:
            begin
                send_byte(len[15:8]);
                send_byte(len[7:0]);
                n = len;
            end
            tsd_pkg::TAG_U64:  n = 8;
            tsd_pkg::TAG_U32:  n = 4;
            tsd_pkg::TAG_U16:  n = 2;
            tsd_pkg::TAG_U8:   n = 1;
            tsd_pkg::TAG_ADDR: n = 16;
            default:           n = 0;
        endcase
        for (int i = 0; i < n; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hff;
                default:   b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
    endtask

    // Hold the stream until every expected record has arrived
    task automatic drain_results();
        if (sending)
        begin
            stream_ch.valid <= 1'b0;
            sending = 1'b0;
        end
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [tsd_pkg::PADDR_W-1:0] addr,
                             input logic [tsd_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MAX_RAW_LENGTH)
            raw_limit = value[15:0];
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [tsd_pkg::PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        check_field("max_raw_length", 64'({16'h0, raw_limit}), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] limit);
        apb_write(ADDR_MAX_RAW_LENGTH, {16'($urandom_range(0, 65535)), limit});
        apb_read_check(ADDR_MAX_RAW_LENGTH);
    endtask

    // List kinds, unknown tags, short integers, empty and short strings
    task automatic test_directed_items();
        logic [7:0] seq [$];
        seq = '{tsd_pkg::TAG_LIST_START, tsd_pkg::TAG_LIST_STOP, 8'h00, 8'hff, 8'h0b,
                tsd_pkg::TAG_U8, 8'hff,
                tsd_pkg::TAG_U16, 8'h80, 8'h01,
                tsd_pkg::TAG_STRING, 8'h00, 8'h00,
                tsd_pkg::TAG_RAW, 8'h00, 8'h00,
                tsd_pkg::TAG_STRING, 8'h00, 8'h02, 8'h41, 8'h42,
                tsd_pkg::TAG_U32, 8'hff, 8'hff, 8'hff, 8'hff};
        gaps_on = 1'b0;
        foreach (seq[i])
            send_byte(seq[i]);
        drain_results();
    endtask

    // Raw lengths on both sides of the limit, a long raw, unmapped writes
    task automatic test_raw_length_limit();
        logic [15:0] limits [$];
        apb_read_check(ADDR_MAX_RAW_LENGTH);
        gaps_on = 1'b1;
        send_tlv(tsd_pkg::TAG_RAW, 9, FILL_RANDOM);
        drain_results();

        limits = '{16'd0, 16'd1, 16'd5, 16'($urandom_range(2, 40))};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            send_tlv(tsd_pkg::TAG_RAW, 32'(limits[i]), FILL_RANDOM);
            send_tlv(tsd_pkg::TAG_RAW, 32'(limits[i]) + 32'd1, FILL_RANDOM);
            send_tlv(tsd_pkg::TAG_STRING, 32'(limits[i]) + 32'd1, FILL_RANDOM);
            drain_results();
        end

        // Raw one past a limit whose length needs both length bytes
        write_limit(16'h00ff);
        send_tlv(tsd_pkg::TAG_RAW, 256, FILL_RANDOM);
        drain_results();

        // Write past the register list must leave the limit alone
        apb_write(ADDR_UNMAPPED, $urandom());
        apb_read_check(ADDR_MAX_RAW_LENGTH);

        write_limit(tsd_pkg::MAX_RAW_LENGTH_RST);
        send_tlv(tsd_pkg::TAG_RAW, 3, FILL_ONES);
        drain_results();
    endtask

    // Mostly well-formed items with random content, some stray and cut-off bytes
    task automatic test_random_stream();
        int unsigned stop_at;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned len;
        fill_t       fill;
        logic [7:0]  tag;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            case ($urandom_range(0, 3))
                0:       write_limit(16'd0);
                1:       write_limit(16'hffff);
                default: write_limit(16'($urandom_range(0, 40)));
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                tag  = KNOWN_TAGS[$urandom_range(0, 8)];
                if (pick < 10)
                    send_byte(8'($urandom_range(0, 255)));
                else if (pick < 15)
                    send_byte(tag);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        len = $urandom_range(0, 8);
                    else if (pick < 97)
                        len = $urandom_range(9, 48);
                    else
                        len = $urandom_range(200, 300);
                    pick = $urandom_range(0, 99);
                    fill = (pick < 10) ? FILL_ZERO : (pick < 20) ? FILL_ONES : FILL_RANDOM;
                    send_tlv(tag, len, fill);
                end
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        stream_ch.valid = 1'b0;
        stream_ch.data  = '0;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_items();
        test_raw_length_limit();
        test_random_stream();
        drain_results();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
